// ===== rtl/normal_equation_accumulator_core_defines.svh =====
`ifndef NORMAL_EQUATION_ACCUMULATOR_CORE_DEFINES_SVH
`define NORMAL_EQUATION_ACCUMULATOR_CORE_DEFINES_SVH

// expr must never hold
`define NEA_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define NEA_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nea_pkg.sv =====
package nea_pkg;

    localparam int MAX_TERMS_DEF = 8;
    localparam int ACC_WIDTH_DEF = 48;

    localparam int ROW_FIELDS = 8;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int OUT_W      = 48;
    localparam int ROW_IDX_W  = 3;
    localparam int TERMS_W    = 4;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [TERMS_W-1:0] TERMS_RESET = 4'd8;

    localparam logic REG_TERMS_IN_USE = 1'b0;

    typedef struct packed {
        logic                 load;
        logic                 acc_en;
        logic                 rd_en;
        logic                 out_load;
        logic                 clear;
        logic [ROW_IDX_W-1:0] row;
        logic                 last;
    } nea_cmd_t;

    typedef struct packed {
        logic wr_pend;
    } nea_stat_t;

endpackage

// ===== rtl/nea_if.sv =====
interface nea_row_if;
    import nea_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] row_value_0;
    logic signed [SAMPLE_W-1:0] row_value_1;
    logic signed [SAMPLE_W-1:0] row_value_2;
    logic signed [SAMPLE_W-1:0] row_value_3;
    logic signed [SAMPLE_W-1:0] row_value_4;
    logic signed [SAMPLE_W-1:0] row_value_5;
    logic signed [SAMPLE_W-1:0] row_value_6;
    logic signed [SAMPLE_W-1:0] row_value_7;
    logic signed [SAMPLE_W-1:0] target_value;
    logic                       final_row;

    modport source (
        output valid, row_value_0, row_value_1, row_value_2, row_value_3,
               row_value_4, row_value_5, row_value_6, row_value_7,
               target_value, final_row,
        input  ready
    );

    modport sink (
        input  valid, row_value_0, row_value_1, row_value_2, row_value_3,
               row_value_4, row_value_5, row_value_6, row_value_7,
               target_value, final_row,
        output ready
    );
endinterface

interface nea_result_if;
    import nea_pkg::*;

    logic                        valid;
    logic                        ready;
    logic        [ROW_IDX_W-1:0] matrix_row;
    logic signed [OUT_W-1:0]     gram_0;
    logic signed [OUT_W-1:0]     gram_1;
    logic signed [OUT_W-1:0]     gram_2;
    logic signed [OUT_W-1:0]     gram_3;
    logic signed [OUT_W-1:0]     gram_4;
    logic signed [OUT_W-1:0]     gram_5;
    logic signed [OUT_W-1:0]     gram_6;
    logic signed [OUT_W-1:0]     gram_7;
    logic signed [OUT_W-1:0]     rhs_sum;
    logic                        last_result;

    modport source (
        output valid, matrix_row, gram_0, gram_1, gram_2, gram_3, gram_4,
               gram_5, gram_6, gram_7, rhs_sum, last_result,
        input  ready
    );

    modport sink (
        input  valid, matrix_row, gram_0, gram_1, gram_2, gram_3, gram_4,
               gram_5, gram_6, gram_7, rhs_sum, last_result,
        output ready
    );
endinterface

// ===== rtl/normal_equation_accumulator_core.sv =====
// Channel     Dir  Beat                                  Handshake
// row_in      in   one design row, target, final flag    valid/ready
// result_out  out  one Gram row with its rhs entry       valid/ready
// apb         in   terms_in_use at byte address 0        psel/penable, pready high
//
// A row is taken in the idle state, then updates n Gram rows (n = terms_in_use clamped
// to 1..MAX_TERMS), one read-modify-write of a Gram row per cycle on the single
// write port of the accumulator RAM.
// A final row then waits in S_FLUSH for the last write; each result beat passes S_RD, S_LOAD, S_OUT.
// Reset clears the row flags of the RAM at once; no clearing pass.
// A result beat holds until taken; no row is accepted during update or readout.
module normal_equation_accumulator_core #(
    parameter int MAX_TERMS = nea_pkg::MAX_TERMS_DEF,
    parameter int ACC_WIDTH = nea_pkg::ACC_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nea_pkg::PADDR_W-1:0]  paddr,
    input  logic [nea_pkg::PDATA_W-1:0]  pwdata,
    output logic [nea_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    nea_row_if.sink                      row_in,
    nea_result_if.source                 result_out
);
    import nea_pkg::*;

    logic [TERMS_W-1:0]         terms_reg;
    logic [TERMS_W-1:0]         n;
    logic                       reg_hit;
    nea_cmd_t                   cmd;
    nea_stat_t                  stat;
    logic signed [SAMPLE_W-1:0] row_value [ROW_FIELDS];
    logic signed [OUT_W-1:0]    gram [ROW_FIELDS];

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_TERMS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_reg <= TERMS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            terms_reg <= pwdata[TERMS_W-1:0];
        end
    end

    assign prdata = reg_hit ? PDATA_W'(terms_reg) : '0;

    always_comb
    begin
        priority if (terms_reg == '0)
        begin
            n = TERMS_W'(1);
        end
        else if (terms_reg > TERMS_W'(MAX_TERMS))
        begin
            n = TERMS_W'(MAX_TERMS);
        end
        else
        begin
            n = terms_reg;
        end
    end

    assign row_value[0] = row_in.row_value_0;
    assign row_value[1] = row_in.row_value_1;
    assign row_value[2] = row_in.row_value_2;
    assign row_value[3] = row_in.row_value_3;
    assign row_value[4] = row_in.row_value_4;
    assign row_value[5] = row_in.row_value_5;
    assign row_value[6] = row_in.row_value_6;
    assign row_value[7] = row_in.row_value_7;

    nea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n),
        .in_valid  (row_in.valid),
        .in_final  (row_in.final_row),
        .in_ready  (row_in.ready),
        .out_ready (result_out.ready),
        .out_valid (result_out.valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    nea_dp #(
        .MAX_TERMS (MAX_TERMS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .n            (n),
        .cmd          (cmd),
        .stat         (stat),
        .row_value    (row_value),
        .target_value (row_in.target_value),
        .matrix_row   (result_out.matrix_row),
        .gram         (gram),
        .rhs_sum      (result_out.rhs_sum),
        .last_result  (result_out.last_result)
    );

    assign result_out.gram_0 = gram[0];
    assign result_out.gram_1 = gram[1];
    assign result_out.gram_2 = gram[2];
    assign result_out.gram_3 = gram[3];
    assign result_out.gram_4 = gram[4];
    assign result_out.gram_5 = gram[5];
    assign result_out.gram_6 = gram[6];
    assign result_out.gram_7 = gram[7];
endmodule

// ===== rtl/nea_ram.sv =====
module nea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/nea_ctrl.sv =====
`include "normal_equation_accumulator_core_defines.svh"

module nea_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [nea_pkg::TERMS_W-1:0]  n,
    input  logic                         in_valid,
    input  logic                         in_final,
    output logic                         in_ready,
    input  logic                         out_ready,
    output logic                         out_valid,
    output nea_pkg::nea_cmd_t            cmd,
    input  nea_pkg::nea_stat_t           stat
);
    import nea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_FLUSH,
        S_RD,
        S_LOAD,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [ROW_IDX_W-1:0] k_reg, k_next;
    logic                 final_reg, final_next;
    logic                 last;

    assign last = ({1'b0, k_reg} == (n - TERMS_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        final_next = final_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ACC;
                    k_next     = '0;
                    final_next = in_final;
                end
            end
            S_ACC:
            begin
                if (last)
                begin
                    state_next = final_reg ? S_FLUSH : S_IDLE;
                    k_next     = '0;
                end
                else
                begin
                    k_next = k_reg + ROW_IDX_W'(1);
                end
            end
            S_FLUSH:
            begin
                if (!stat.wr_pend)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = S_IDLE;
                        k_next     = '0;
                    end
                    else
                    begin
                        state_next = S_RD;
                        k_next     = k_reg + ROW_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            final_reg <= final_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.acc_en   = (state_reg == S_ACC);
        cmd.rd_en    = (state_reg == S_ACC) || (state_reg == S_RD);
        cmd.out_load = (state_reg == S_LOAD);
        cmd.clear    = (state_reg == S_OUT) && out_ready && last;
        cmd.row      = k_reg;
        cmd.last     = last;
    end

    `NEA_NEVER(a_no_overlap, in_ready && out_valid, "input taken during readout")
    `NEA_NEXT(a_burst_end, (state_reg == S_OUT) && out_ready && last, in_ready,
              "block not idle after last beat")
endmodule

// ===== rtl/nea_dp.sv =====
`include "normal_equation_accumulator_core_defines.svh"

module nea_dp #(
    parameter int MAX_TERMS = nea_pkg::MAX_TERMS_DEF,
    parameter int ACC_WIDTH = nea_pkg::ACC_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic        [nea_pkg::TERMS_W-1:0]    n,
    input  nea_pkg::nea_cmd_t                     cmd,
    output nea_pkg::nea_stat_t                    stat,
    input  logic signed [nea_pkg::SAMPLE_W-1:0]   row_value [nea_pkg::ROW_FIELDS],
    input  logic signed [nea_pkg::SAMPLE_W-1:0]   target_value,
    output logic        [nea_pkg::ROW_IDX_W-1:0]  matrix_row,
    output logic signed [nea_pkg::OUT_W-1:0]      gram [nea_pkg::ROW_FIELDS],
    output logic signed [nea_pkg::OUT_W-1:0]      rhs_sum,
    output logic                                  last_result
);
    import nea_pkg::*;

    localparam int COLS   = MAX_TERMS + 1;
    localparam int WORD_W = COLS * ACC_WIDTH;
    localparam int RA_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [OUT_W-1:0]     OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]     OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [SAMPLE_W-1:0] x_reg [ROW_FIELDS];
    logic signed [SAMPLE_W-1:0] t_reg;
    logic signed [PROD_W-1:0]   prod_next [COLS];
    logic signed [PROD_W-1:0]   prod_reg  [COLS];
    logic signed [PROD_W-1:0]   xk_ext;
    logic [RA_W-1:0]            raddr;
    logic [RA_W-1:0]            wr_row_reg;
    logic                       wr_pend_reg;
    logic                       rd_valid_reg;
    logic [MAX_TERMS-1:0]       rv_reg;
    logic [WORD_W-1:0]          rdata;
    logic [WORD_W-1:0]          wdata;
    logic signed [ACC_WIDTH-1:0] old_acc [COLS];
    logic signed [OUT_W-1:0]    em [COLS];
    logic signed [OUT_W-1:0]    gram_sel [ROW_FIELDS];

    logic        [ROW_IDX_W-1:0] row_out_reg;
    logic signed [OUT_W-1:0]     gram_reg [ROW_FIELDS];
    logic signed [OUT_W-1:0]     rhs_reg;
    logic                        last_reg;

    assign raddr  = cmd.row[RA_W-1:0];
    assign xk_ext = PROD_W'(x_reg[cmd.row]);

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        logic signed [ACC_WIDTH:0] sum;

        if (c < MAX_TERMS)
        begin : g_gram
            assign prod_next[c] = (TERMS_W'(c) < n) ? xk_ext * PROD_W'(x_reg[c]) : '0;
        end
        else
        begin : g_rhs
            assign prod_next[c] = xk_ext * PROD_W'(t_reg);
        end

        assign old_acc[c] = rd_valid_reg ? rdata[c*ACC_WIDTH +: ACC_WIDTH] : '0;
        assign sum = (ACC_WIDTH+1)'(old_acc[c]) + (ACC_WIDTH+1)'(prod_reg[c]);
        assign wdata[c*ACC_WIDTH +: ACC_WIDTH] =
            (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) ? (sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX)
                                                  : sum[ACC_WIDTH-1:0];

        if (ACC_WIDTH > OUT_W)
        begin : g_sat
            logic fits;
            assign fits = (&old_acc[c][ACC_WIDTH-1:OUT_W-1])
                        || !(|old_acc[c][ACC_WIDTH-1:OUT_W-1]);
            assign em[c] = fits ? old_acc[c][OUT_W-1:0]
                                : (old_acc[c][ACC_WIDTH-1] ? OUT_MIN : OUT_MAX);
        end
        else
        begin : g_ext
            assign em[c] = OUT_W'(old_acc[c]);
        end
    end

    for (genvar j = 0; j < ROW_FIELDS; j++)
    begin : g_out
        if (j < MAX_TERMS)
        begin : g_used
            assign gram_sel[j] = (TERMS_W'(j) < n) ? em[j] : '0;
        end
        else
        begin : g_unused
            assign gram_sel[j] = '0;
        end
    end

    nea_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TERMS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (wr_pend_reg),
        .waddr (wr_row_reg),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg       <= '0;
            wr_pend_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.acc_en;
            if (cmd.rd_en)
            begin
                rd_valid_reg <= rv_reg[raddr];
            end
            if (cmd.clear)
            begin
                rv_reg <= '0;
            end
            else if (wr_pend_reg)
            begin
                rv_reg[wr_row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= row_value;
            t_reg <= target_value;
        end
        if (cmd.acc_en)
        begin
            prod_reg   <= prod_next;
            wr_row_reg <= raddr;
        end
        if (cmd.out_load)
        begin
            row_out_reg <= cmd.row;
            last_reg    <= cmd.last;
            gram_reg    <= gram_sel;
            rhs_reg     <= em[MAX_TERMS];
        end
    end

    assign stat.wr_pend = wr_pend_reg;
    assign matrix_row   = row_out_reg;
    assign gram         = gram_reg;
    assign rhs_sum      = rhs_reg;
    assign last_result  = last_reg;

    `NEA_NEVER(a_rd_wr_clash, cmd.rd_en && wr_pend_reg && (raddr == wr_row_reg),
               "read of a row whose update is still in flight")
    `NEA_NEXT(a_clear_flags, cmd.clear, rv_reg == '0, "row flags not cleared")
endmodule

// ===== verif/normal_equation_checker.sv =====
module normal_equation_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [nea_pkg::PADDR_W-1:0]  paddr,
    input  logic [nea_pkg::PDATA_W-1:0]  pwdata,
    nea_row_if                           row_mon,
    nea_result_if                        res_mon,
    output int                           mismatches,
    output int                           pending
);
    import nea_pkg::*;

    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -64'sd140737488355328;
    localparam logic [PADDR_W-1:0] TERMS_ADDR = {REG_TERMS_IN_USE, 2'b00};

    typedef struct packed {
        logic [ROW_IDX_W-1:0]             matrix_row;
        logic [ROW_FIELDS-1:0][OUT_W-1:0] gram;
        logic [OUT_W-1:0]                 rhs_sum;
        logic                             last_result;
    } gram_row_t;

    longint             gram_acc [MAX_TERMS_DEF][MAX_TERMS_DEF];
    longint             rhs_acc [MAX_TERMS_DEF];
    logic [TERMS_W-1:0] terms_reg;
    gram_row_t          awaited_rows [$];
    int                 fail_tally = 0;
    int                 queue_depth = 0;

    assign mismatches = fail_tally;
    assign pending    = queue_depth;

    function automatic int active_terms();
        if (terms_reg == 0)
            return 1;
        if (terms_reg > MAX_TERMS_DEF)
            return MAX_TERMS_DEF;
        return int'(terms_reg);
    endfunction

    function automatic longint sat_add(longint acc, longint prod);
        longint sum;
        sum = acc + prod;
        if (sum > ACC_HI)
            return ACC_HI;
        if (sum < ACC_LO)
            return ACC_LO;
        return sum;
    endfunction

    function automatic void compare_field(string name, logic [OUT_W-1:0] want,
                                          logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_tally++;
        end
    endfunction

    function automatic void fold_row();
        longint    x [ROW_FIELDS];
        longint    t;
        int        n;
        gram_row_t beat;
        x[0] = longint'(row_mon.row_value_0);
        x[1] = longint'(row_mon.row_value_1);
        x[2] = longint'(row_mon.row_value_2);
        x[3] = longint'(row_mon.row_value_3);
        x[4] = longint'(row_mon.row_value_4);
        x[5] = longint'(row_mon.row_value_5);
        x[6] = longint'(row_mon.row_value_6);
        x[7] = longint'(row_mon.row_value_7);
        t = longint'(row_mon.target_value);
        n = active_terms();
        for (int k = 0; k < n; k++)
        begin
            for (int j = 0; j < n; j++)
                gram_acc[k][j] = sat_add(gram_acc[k][j], x[k] * x[j]);
            rhs_acc[k] = sat_add(rhs_acc[k], x[k] * t);
        end
        if (row_mon.final_row !== 1'b1)
            return;
        for (int k = 0; k < n; k++)
        begin
            beat.matrix_row = ROW_IDX_W'(k);
            for (int j = 0; j < ROW_FIELDS; j++)
                beat.gram[j] = (j < n) ? OUT_W'(gram_acc[k][j]) : '0;
            beat.rhs_sum     = OUT_W'(rhs_acc[k]);
            beat.last_result = (k == n - 1);
            awaited_rows.push_back(beat);
        end
        gram_acc = '{default: 0};
        rhs_acc  = '{default: 0};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gram_row_t got;
        gram_row_t want;
        if (!rst_n)
        begin
            gram_acc  = '{default: 0};
            rhs_acc   = '{default: 0};
            terms_reg = TERMS_RESET;
            awaited_rows.delete();
            queue_depth = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == TERMS_ADDR)
                terms_reg = pwdata[TERMS_W-1:0];
            if (res_mon.valid && res_mon.ready)
            begin
                got.matrix_row  = res_mon.matrix_row;
                got.gram[0]     = res_mon.gram_0;
                got.gram[1]     = res_mon.gram_1;
                got.gram[2]     = res_mon.gram_2;
                got.gram[3]     = res_mon.gram_3;
                got.gram[4]     = res_mon.gram_4;
                got.gram[5]     = res_mon.gram_5;
                got.gram[6]     = res_mon.gram_6;
                got.gram[7]     = res_mon.gram_7;
                got.rhs_sum     = res_mon.rhs_sum;
                got.last_result = res_mon.last_result;
                if (awaited_rows.size() == 0)
                begin
                    $error("result beat for matrix row %0d with none awaited",
                           got.matrix_row);
                    fail_tally++;
                end
                else
                begin
                    want = awaited_rows.pop_front();
                    compare_field("matrix_row", want.matrix_row, got.matrix_row);
                    for (int j = 0; j < ROW_FIELDS; j++)
                        compare_field($sformatf("gram_%0d", j), want.gram[j], got.gram[j]);
                    compare_field("rhs_sum", want.rhs_sum, got.rhs_sum);
                    compare_field("last_result", want.last_result, got.last_result);
                end
            end
            if (row_mon.valid && row_mon.ready)
                fold_row();
            queue_depth = awaited_rows.size();
        end
    end

endmodule

// ===== verif/normal_equation_accumulator_core_tb.sv =====
module normal_equation_accumulator_core_tb;
    import nea_pkg::*;

    localparam int  QUIET_LIMIT   = 2000;
    localparam int  SQUEEZE_LEN   = 240;
    localparam logic [PADDR_W-1:0] TERMS_ADDR = {REG_TERMS_IN_USE, 2'b00};

    typedef logic [ROW_FIELDS-1:0][SAMPLE_W-1:0] row_vec_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 mismatches;
    int                 pending;
    int                 quiet_cycles = 0;
    bit                 steady = 1'b0;
    bit                 squeeze = 1'b0;
    bit                 squeezed = 1'b0;

    nea_row_if    row_ch ();
    nea_result_if res_ch ();

    normal_equation_accumulator_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .row_in     (row_ch),
        .result_out (res_ch)
    );

    normal_equation_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .row_mon    (row_ch),
        .res_mon    (res_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("normal_equation_accumulator_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze && !squeezed)
            begin
                hold_left = SQUEEZE_LEN;
                squeezed  = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = steady || ($urandom_range(0, 99) >= 17);
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic write_terms(input logic [TERMS_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = TERMS_ADDR;
        pwdata  = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic send_row(input row_vec_t vals, input logic [SAMPLE_W-1:0] target,
                            input bit last);
        if (!steady && $urandom_range(0, 99) < 17)
        begin
            row_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        row_ch.row_value_0  = vals[0];
        row_ch.row_value_1  = vals[1];
        row_ch.row_value_2  = vals[2];
        row_ch.row_value_3  = vals[3];
        row_ch.row_value_4  = vals[4];
        row_ch.row_value_5  = vals[5];
        row_ch.row_value_6  = vals[6];
        row_ch.row_value_7  = vals[7];
        row_ch.target_value = target;
        row_ch.final_row    = last;
        row_ch.valid        = 1'b1;
        do
            @(posedge clk);
        while (!row_ch.ready);
        @(negedge clk);
        row_ch.valid = 1'b0;
    endtask

    task automatic send_random_set(input int rows);
        row_vec_t vals;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < ROW_FIELDS; c++)
                vals[c] = pick_sample();
            send_row(vals, pick_sample(), r == rows - 1);
        end
    endtask

    initial
    begin
        logic [TERMS_W-1:0] phase_terms [6];
        int                 budget;
        int                 rows;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        row_ch.valid        = 1'b0;
        row_ch.row_value_0  = '0;
        row_ch.row_value_1  = '0;
        row_ch.row_value_2  = '0;
        row_ch.row_value_3  = '0;
        row_ch.row_value_4  = '0;
        row_ch.row_value_5  = '0;
        row_ch.row_value_6  = '0;
        row_ch.row_value_7  = '0;
        row_ch.target_value = '0;
        row_ch.final_row    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset width of eight terms
        send_row({ROW_FIELDS{16'h8000}}, 16'h7FFF, 1'b1);
        send_row({ROW_FIELDS{16'h7FFF}}, 16'h8000, 1'b0);
        send_row({4{16'h8000, 16'h7FFF}}, 16'h0000, 1'b0);
        send_row({ROW_FIELDS{16'h0000}}, 16'hFFFF, 1'b1);
        send_row({4{16'hAAAA, 16'h5555}}, 16'h00FF, 1'b1);
        settle();

        // single term, outer columns must be ignored
        write_terms(4'd1);
        send_row({16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h0F0F, 16'h8001, 16'h4000,
                  16'hC000}, 16'h7FFF, 1'b0);
        send_row({16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666, 16'h7777,
                  16'h8000}, 16'h8000, 1'b1);
        settle();

        // zero acts as one
        write_terms(4'd0);
        send_row({ROW_FIELDS{16'h8000}}, 16'h8000, 1'b1);
        settle();

        // above the maximum acts as the maximum
        write_terms(4'd15);
        send_row({4{16'h7FFF, 16'h8000}}, 16'h7FFF, 1'b0);
        send_row({ROW_FIELDS{16'hFFFF}}, 16'h0001, 1'b1);
        settle();

        write_terms(4'd5);
        send_row({16'h0001, 16'h0002, 16'h0003, 16'h7FFF, 16'h8000, 16'h0002, 16'h0001,
                  16'h7FFF}, 16'h0004, 1'b0);
        send_row({ROW_FIELDS{16'h7FFF}}, 16'h7FFF, 1'b0);
        send_row({ROW_FIELDS{16'h8000}}, 16'h8000, 1'b1);
        settle();

        phase_terms[0] = 4'd8;
        phase_terms[1] = 4'd3;
        phase_terms[2] = TERMS_W'($urandom_range(0, 15));
        phase_terms[3] = 4'd2;
        phase_terms[4] = TERMS_W'($urandom_range(1, 8));
        phase_terms[5] = 4'd7;
        for (int p = 0; p < 6; p++)
        begin
            write_terms(phase_terms[p]);
            steady = (p == 4);
            budget = 14;
            while (budget > 0)
            begin
                rows = $urandom_range(1, 5);
                if (rows > budget)
                    rows = budget;
                send_random_set(rows);
                budget -= rows;
            end
            if (p == 2)
            begin
                // hold the result side off while rows keep arriving
                squeeze = 1'b1;
                repeat (5) send_random_set(2);
                squeeze = 1'b0;
            end
            steady = 1'b0;
            settle();
        end

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("normal_equation_accumulator_core verification clean");
        else
            $display("normal_equation_accumulator_core verification failed");
        $finish;
    end

endmodule
